// ----- hdl/ostb_pkg.sv -----
// ----------------------------------------------------------------------------
// ostb_pkg
// Types and constants shared by the one-shot timer bank modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ostb_pkg;

    // Bank size and fixed field widths
    localparam int NUM_TIMERS = 6;
    localparam int TIMER_W    = 6;
    localparam int ID_W       = 3;
    localparam int TIME_W     = 32;

    localparam logic [ID_W-1:0]    ID_LIMIT     = ID_W'(NUM_TIMERS);
    localparam logic [TIMER_W-1:0] MS_MASK_RST  = TIMER_W'(7);

    // Command codes
    typedef enum logic [1:0] {
        CMD_START    = 2'd0,
        CMD_STOP     = 2'd1,
        CMD_STOP_ALL = 2'd2,
        CMD_TICK     = 2'd3
    } t_cmd;

    // One request into the bank
    typedef struct packed {
        t_cmd              command;
        logic [ID_W-1:0]   timer_id;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] now_ms;
        logic [TIME_W-1:0] now_s;
    } t_in_item;

    // One result out of the bank
    typedef struct packed {
        logic               accepted;
        logic [TIMER_W-1:0] fired_mask;
    } t_out_item;

endpackage

`default_nettype wire

// ----- hdl/ostb_in_reg.sv -----
// ----------------------------------------------------------------------------
// ostb_in_reg
// Input register: captures one request and holds it until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ostb_in_reg import ostb_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_data,
    output logic          o_valid,
    output t_in_item      o_data,
    input  wire logic     i_advance
);

    logic     r_valid;
    t_in_item r_data;

    // Take a new request when empty or when the held one moves on this cycle
    assign o_ready = !r_valid || i_advance;

    // Hold the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture the request payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- hdl/ostb_timer_core.sv -----
// ----------------------------------------------------------------------------
// ostb_timer_core
// Timer state, base-select register and the single-pass command logic.
// ----------------------------------------------------------------------------
`default_nettype none

module ostb_timer_core import ostb_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [TIMER_W-1:0] i_cfg_data,
    input  wire t_in_item           i_item,
    input  wire logic               i_advance,
    output t_out_item               o_result
);

    logic [TIMER_W-1:0]    r_ms_mask;
    logic [NUM_TIMERS-1:0] r_armed;
    logic [TIME_W-1:0]     r_deadline [NUM_TIMERS];

    logic [NUM_TIMERS-1:0] n_armed;
    logic [TIME_W-1:0]     n_deadline [NUM_TIMERS];
    logic [TIME_W-1:0]     base_now   [NUM_TIMERS];
    logic [TIME_W-1:0]     diff       [NUM_TIMERS];
    logic [TIMER_W-1:0]    fired;
    logic                  ok;

    // Pick each timer's time base and its distance past the deadline
    always_comb begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            base_now[i] = r_ms_mask[i] ? i_item.now_ms : i_item.now_s;
            diff[i]     = base_now[i] - r_deadline[i];
        end
    end

    // Decode the command and form the next state and result
    always_comb begin
        n_armed = r_armed;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            n_deadline[i] = r_deadline[i];
        end
        ok    = 1'b1;
        fired = '0;
        unique case (i_item.command)
            CMD_START: begin
                if (i_item.timer_id >= ID_LIMIT || i_item.delay == '0) begin
                    ok = 1'b0;
                end else begin
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (i_item.timer_id == ID_W'(i)) begin
                            n_deadline[i] = base_now[i] + i_item.delay;
                            n_armed[i]    = 1'b1;
                        end
                    end
                end
            end
            CMD_STOP: begin
                if (i_item.timer_id >= ID_LIMIT) begin
                    ok = 1'b0;
                end else begin
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (i_item.timer_id == ID_W'(i)) begin
                            n_armed[i] = 1'b0;
                        end
                    end
                end
            end
            CMD_STOP_ALL: begin
                n_armed = '0;
            end
            CMD_TICK: begin
                // Fire only when strictly past the deadline (positive, nonzero)
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (r_armed[i] && diff[i] != '0 && !diff[i][TIME_W-1]) begin
                        n_armed[i] = 1'b0;
                        fired[i]   = 1'b1;
                    end
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    // Hold the base-select register and the armed flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms_mask <= MS_MASK_RST;
            r_armed   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_ms_mask <= i_cfg_data;
            end
            if (i_advance) begin
                r_armed <= n_armed;
            end
        end
    end

    // Update deadlines; only read while armed
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_deadline[i] <= n_deadline[i];
            end
        end
    end

    assign o_result.accepted   = ok;
    assign o_result.fired_mask = fired;

endmodule

`default_nettype wire

// ----- hdl/ostb_out_reg.sv -----
// ----------------------------------------------------------------------------
// ostb_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ostb_out_reg import ostb_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_load,
    input  wire t_out_item i_data,
    output logic           o_can_load,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_data
);

    logic      r_valid;
    t_out_item r_data;

    // Room for a new result when empty or when the held one drains now
    assign o_can_load = !r_valid || i_ready;

    // Track whether a result is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    // Capture the result payload
    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- hdl/one_shot_timer_bank_unit.sv -----
// ----------------------------------------------------------------------------
// one_shot_timer_bank_unit
// Bank of six one-shot timers on millisecond or seconds time bases.
// ----------------------------------------------------------------------------
// The bank takes one request per clock while the result side keeps up and
// returns one result per request. The request sits in the input register
// while the command logic (start adder, six parallel deadline compares for
// a tick) works on it, and the edge that moves it on writes the timer state
// and the result register together. Requests and results flow back to back
// as long as the result side is ready. A stalled result holds the input
// register, which then stops taking requests.
// The base-select register is always ready and should be written while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module one_shot_timer_bank_unit import ostb_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_in_item           i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_item               o_out_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [TIMER_W-1:0] i_cfg_data
);

    logic      held_valid;
    t_in_item  held_item;
    logic      out_can_load;
    logic      advance;
    t_out_item result;

    // Move the held request through the core when the result slot is free
    assign advance     = held_valid && out_can_load;
    assign o_cfg_ready = 1'b1;

    ostb_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_data    (i_in_data),
        .o_valid   (held_valid),
        .o_data    (held_item),
        .i_advance (advance)
    );

    ostb_timer_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_item     (held_item),
        .i_advance  (advance),
        .o_result   (result)
    );

    ostb_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_data     (result),
        .o_can_load (out_can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (o_out_data)
    );

`ifndef SYNTH
    // A fired timer only comes with an accepted tick
    a_fired_implies_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.fired_mask != '0) |-> o_out_data.accepted)
        else $error("fired mask set on a rejected request");

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A full pipe with a stalled result takes no new request
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (held_valid && o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("request accepted while pipe stalled");

    // A stalled result keeps the held request in place
    a_hold_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (held_valid && o_out_valid && !i_out_ready) |=> held_valid)
        else $error("held request lost during stall");
`endif

endmodule

`default_nettype wire

// ----- verif/one_shot_timer_bank_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_shot_timer_bank_unit_tb
// Self-checking bench for the one-shot timer bank.
// ----------------------------------------------------------------------------
// Requests go in over a valid/ready channel and results come back one per
// request. A timer model inside the bench tracks armed flags, deadlines and
// the time-base select, and queues the result each accepted request should
// produce. A directed run covers rejects, exact deadlines, wrap and the
// half-range compare. Random phases under several base masks follow. Both
// sides stall at random, and the result side holds off once for a long time.
// ----------------------------------------------------------------------------

module one_shot_timer_bank_unit_tb;
    import ostb_pkg::*;

    localparam int unsigned LONG_HOLD      = 400;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned PHASE_REQUESTS = 300;
    localparam int unsigned NUM_PHASES     = 6;

    // Timer model and store of expected results
    class timer_bank_scoreboard;
        logic [TIMER_W-1:0] base_ms_sel;
        bit                 armed [NUM_TIMERS];
        logic [TIME_W-1:0]  deadline [NUM_TIMERS];
        t_out_item          result_q [$];
        int unsigned        mismatches;

        function new();
            base_ms_sel = MS_MASK_RST;
            mismatches  = 0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                armed[i]    = 1'b0;
                deadline[i] = '0;
            end
        endfunction

        function void set_base_mask(logic [TIMER_W-1:0] mask);
            base_ms_sel = mask;
        endfunction

        function logic [TIME_W-1:0] base_time(int idx, t_in_item r);
            return base_ms_sel[idx] ? r.now_ms : r.now_s;
        endfunction

        function int pending();
            return result_q.size();
        endfunction

        // Apply one request to the model and queue its result
        function void note_request(t_in_item r);
            t_out_item         res;
            logic [TIME_W-1:0] lag;
            res.accepted   = 1'b1;
            res.fired_mask = '0;
            case (r.command)
                CMD_START: begin
                    if (r.timer_id >= ID_LIMIT || r.delay == '0) begin
                        res.accepted = 1'b0;
                    end else begin
                        deadline[r.timer_id] = base_time(r.timer_id, r) + r.delay;
                        armed[r.timer_id]    = 1'b1;
                    end
                end
                CMD_STOP: begin
                    if (r.timer_id >= ID_LIMIT) begin
                        res.accepted = 1'b0;
                    end else begin
                        armed[r.timer_id] = 1'b0;
                    end
                end
                CMD_STOP_ALL: begin
                    for (int i = 0; i < NUM_TIMERS; i++) armed[i] = 1'b0;
                end
                default: begin
                    // Fire only when strictly past the deadline, within half range
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (armed[i]) begin
                            lag = base_time(i, r) - deadline[i];
                            if (lag != '0 && !lag[TIME_W-1]) begin
                                armed[i]          = 1'b0;
                                res.fired_mask[i] = 1'b1;
                            end
                        end
                    end
                end
            endcase
            result_q.push_back(res);
        endfunction

        // Compare one result with the oldest expectation
        function void check_result(t_out_item got);
            t_out_item want;
            if (result_q.size() == 0) begin
                $error("result with no request outstanding: accepted %0d fired_mask %02h",
                       got.accepted, got.fired_mask);
                mismatches++;
                return;
            end
            want = result_q.pop_front();
            if (got.accepted !== want.accepted) begin
                $error("accepted: expected %0d, actual %0d", want.accepted, got.accepted);
                mismatches++;
            end
            if (got.fired_mask !== want.fired_mask) begin
                $error("fired_mask: expected %02h, actual %02h",
                       want.fired_mask, got.fired_mask);
                mismatches++;
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    t_in_item           in_data   = '0;
    logic               out_ready = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [TIMER_W-1:0] cfg_data  = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    t_out_item          o_out_data;
    logic               o_cfg_ready;

    timer_bank_scoreboard sb = new();

    logic [TIME_W-1:0] ms_now        = '0;
    logic [TIME_W-1:0] s_now         = '0;
    bit                tx_steady     = 1'b0;
    bit                long_hold_req = 1'b0;
    int unsigned       idle_cycles   = 0;

    one_shot_timer_bank_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Build one request from its fields
    function automatic t_in_item mk(t_cmd c, int unsigned id, logic [TIME_W-1:0] dly,
                                    logic [TIME_W-1:0] t_ms, logic [TIME_W-1:0] t_s);
        t_in_item r;
        r.command  = c;
        r.timer_id = ID_W'(id);
        r.delay    = dly;
        r.now_ms   = t_ms;
        r.now_s    = t_s;
        return r;
    endfunction

    // Pick the idle cycles before the next request
    function automatic int unsigned sender_gap();
        int unsigned pick;
        if (tx_steady) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 88) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Random request; time mostly advances slowly so armed timers expire
    function automatic t_in_item random_request();
        t_in_item    r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)      r.command = CMD_START;
        else if (pick < 50) r.command = CMD_STOP;
        else if (pick < 53) r.command = CMD_STOP_ALL;
        else                r.command = CMD_TICK;
        if ($urandom_range(0, 9) == 0)
            r.timer_id = ID_W'($urandom_range(NUM_TIMERS, (1 << ID_W) - 1));
        else
            r.timer_id = ID_W'($urandom_range(0, NUM_TIMERS - 1));
        pick = $urandom_range(0, 99);
        if (pick < 5)       r.delay = '0;
        else if (pick < 80) r.delay = $urandom_range(1, 40);
        else if (pick < 90) r.delay = $urandom;
        else                r.delay = 32'h7FFF_FFFE + $urandom_range(0, 3);
        if ($urandom_range(0, 99) < 3) begin
            ms_now = $urandom;
            s_now  = $urandom;
        end else begin
            ms_now = ms_now + $urandom_range(0, 8);
            s_now  = s_now + ($urandom_range(0, 2) == 0);
        end
        r.now_ms = ms_now;
        r.now_s  = s_now;
        // Stop commands ignore time, so let them carry junk now and then
        if ((r.command == CMD_STOP || r.command == CMD_STOP_ALL) && $urandom_range(0, 1)) begin
            r.now_ms = $urandom;
            r.now_s  = $urandom;
        end
        return r;
    endfunction

    // Offer one request after a gap and hold it until accepted
    task automatic send_request(input t_in_item r, input int unsigned gap);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        sb.note_request(r);
    endtask

    // Drop the request line and wait for every outstanding result
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_base_mask(input logic [TIMER_W-1:0] mask);
        cfg_valid <= 1'b1;
        cfg_data  <= mask;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        sb.set_base_mask(mask);
        cfg_valid <= 1'b0;
    endtask

    // Result side: ready stretches, short stalls, and one long hold-off on request
    initial begin : result_sink
        int unsigned ready_len;
        int unsigned stall_len;
        int unsigned pick;
        int unsigned n;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                ready_len     = 1;
                stall_len     = LONG_HOLD;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    ready_len = $urandom_range(50, 200);
                    stall_len = 0;
                end else if (pick < 95) begin
                    ready_len = $urandom_range(1, 6);
                    stall_len = $urandom_range(0, 3);
                end else begin
                    ready_len = $urandom_range(1, 6);
                    stall_len = $urandom_range(15, 60);
                end
            end
            out_ready <= 1'b1;
            n = 0;
            do begin
                @(posedge clk);
                n++;
            end while (n < ready_len && !long_hold_req);
            if (stall_len != 0) begin
                out_ready <= 1'b0;
                repeat (stall_len) @(posedge clk);
            end
        end
    end

    // Check results and watch for a stuck handshake
    always @(posedge clk) begin
        if (rst_n) begin
            if (o_out_valid && out_ready) sb.check_result(o_out_data);
            if ((o_out_valid && out_ready) || (in_valid && o_in_ready)
                    || (cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        logic [TIMER_W-1:0] mask;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed checks under the reset base mask (timers 0-2 ms, 3-5 seconds)
        send_request(mk(CMD_TICK, 0, 0, 0, 0), sender_gap());
        send_request(mk(CMD_START, 6, 5, 0, 0), sender_gap());
        send_request(mk(CMD_START, 7, '1, '1, '1), sender_gap());
        send_request(mk(CMD_STOP, 7, 0, 0, 0), sender_gap());
        send_request(mk(CMD_START, 0, 0, 100, 0), sender_gap());
        send_request(mk(CMD_START, 0, 10, 100, 0), sender_gap());
        send_request(mk(CMD_START, 3, 2, 0, 50), sender_gap());
        // exact deadline holds, one past fires
        send_request(mk(CMD_TICK, 0, 0, 110, 52), sender_gap());
        send_request(mk(CMD_TICK, 0, 0, 111, 53), sender_gap());
        send_request(mk(CMD_TICK, 0, 0, 500, 500), sender_gap());
        // stopped timer keeps its deadline but never fires
        send_request(mk(CMD_START, 1, 5, 200, 0), sender_gap());
        send_request(mk(CMD_STOP, 1, 0, 200, 0), sender_gap());
        send_request(mk(CMD_TICK, 0, 0, 300, 0), sender_gap());
        send_request(mk(CMD_STOP, 2, 0, 0, 0), sender_gap());
        // deadline wraps past zero
        send_request(mk(CMD_START, 2, '1, 32'h10, 0), sender_gap());
        send_request(mk(CMD_TICK, 0, 0, 32'h20, 0), sender_gap());
        // half-range difference counts as not yet due
        send_request(mk(CMD_START, 4, 32'h8000_0000, 0, 0), sender_gap());
        send_request(mk(CMD_TICK, 0, 0, 0, 0), sender_gap());
        send_request(mk(CMD_TICK, 0, 0, 0, 32'h8000_0001), sender_gap());
        // restart replaces the deadline
        send_request(mk(CMD_START, 5, 100, 0, 10), sender_gap());
        send_request(mk(CMD_START, 5, 3, 0, 10), sender_gap());
        send_request(mk(CMD_TICK, 0, 0, 0, 14), sender_gap());
        send_request(mk(CMD_START, 0, 1, 0, 0), sender_gap());
        send_request(mk(CMD_START, 3, 1, 0, 0), sender_gap());
        send_request(mk(CMD_STOP_ALL, 0, 0, 0, 0), sender_gap());
        send_request(mk(CMD_TICK, 0, 0, '1, '1), sender_gap());
        wait_drained();

        // Random phases, each under its own base mask
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       mask = '0;
                1:       mask = '1;
                4:       mask = 6'h2A;
                default: mask = TIMER_W'($urandom);
            endcase
            write_base_mask(mask);
            tx_steady = (p == 1 || p == 2);
            if (p == 2) long_hold_req = 1'b1;
            if (p == 3) begin
                ms_now = 32'hFFFF_FF00;
                s_now  = 32'hFFFF_FFF0;
            end
            for (int k = 0; k < PHASE_REQUESTS; k++) begin
                send_request(random_request(), sender_gap());
                // occasionally pause until the bank has emptied
                if (!tx_steady && $urandom_range(0, 99) == 0) wait_drained();
            end
            wait_drained();
        end

        // Let any stray result show up before the verdict
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/ostb_pkg.sv
hdl/ostb_in_reg.sv
hdl/ostb_timer_core.sv
hdl/ostb_out_reg.sv
hdl/one_shot_timer_bank_unit.sv
verif/one_shot_timer_bank_unit_tb.sv
